[src/rbd_pkg.sv]
`timescale 1ns / 1ps
// shared types for the ring buffer deque: request and status codes,
// controller states, and the command and status groups between modules
package rbd_pkg;

  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_PEEK_FRONT = 3'd4,
    OP_PEEK_BACK  = 3'd5,
    OP_SEARCH     = 3'd6,
    OP_CLEAR      = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_READ,
    S_SCAN,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic accept;
    logic exec;
    logic read_done;
    logic scan_step;
    logic load_out;
  } ctl_cmd_t;

  typedef struct packed {
    op_t  op;
    logic empty;
    logic match;
    logic scan_last;
    logic out_free;
  } dp_status_t;

endpackage

[src/rbd_ctrl.sv]
`timescale 1ns / 1ps
// sequencing state machine for the ring buffer deque
// uses rbd_pkg for states, request codes and the command/status structs
module rbd_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  rbd_pkg::dp_status_t dp_status,
  output logic                in_stall,
  output rbd_pkg::ctl_cmd_t   cmd
);

  rbd_pkg::state_t state, state_next;
  logic is_read_op;
  logic is_search;

  assign is_read_op = (dp_status.op == rbd_pkg::OP_POP_FRONT) ||
                      (dp_status.op == rbd_pkg::OP_POP_BACK) ||
                      (dp_status.op == rbd_pkg::OP_PEEK_FRONT) ||
                      (dp_status.op == rbd_pkg::OP_PEEK_BACK);
  assign is_search  = (dp_status.op == rbd_pkg::OP_SEARCH);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rbd_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      rbd_pkg::S_IDLE: begin
        if (in_valid) state_next = rbd_pkg::S_EXEC;
      end
      rbd_pkg::S_EXEC: begin
        if (is_read_op && !dp_status.empty) state_next = rbd_pkg::S_READ;
        else if (is_search && !dp_status.empty) state_next = rbd_pkg::S_SCAN;
        else state_next = rbd_pkg::S_FINISH;
      end
      rbd_pkg::S_READ: begin
        state_next = rbd_pkg::S_FINISH;
      end
      rbd_pkg::S_SCAN: begin
        if (dp_status.match || dp_status.scan_last) state_next = rbd_pkg::S_FINISH;
      end
      rbd_pkg::S_FINISH: begin
        if (dp_status.out_free) state_next = rbd_pkg::S_IDLE;
      end
      default: begin
        state_next = rbd_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state)
      rbd_pkg::S_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
      end
      rbd_pkg::S_EXEC:   cmd.exec      = 1'b1;
      rbd_pkg::S_READ:   cmd.read_done = 1'b1;
      rbd_pkg::S_SCAN:   cmd.scan_step = 1'b1;
      rbd_pkg::S_FINISH: cmd.load_out  = dp_status.out_free;
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

[src/rbd_datapath.sv]
`timescale 1ns / 1ps
// pointers, count, capacity register, word store and result registers
// of the ring buffer deque; driven by rbd_ctrl through rbd_pkg structs
module rbd_datapath #(
  parameter int DEPTH     = 16,
  parameter int WORD_BITS = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  rbd_pkg::ctl_cmd_t   cmd,
  output rbd_pkg::dp_status_t dp_status,
  input  logic [2:0]          operation,
  input  logic signed [31:0]  data_in,
  input  logic                cfg_we,
  input  logic [4:0]          cfg_wdata,
  output logic [4:0]          cap_value,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          status,
  output logic signed [31:0]  data_out,
  output logic [3:0]          found_slot,
  output logic [4:0]          count_now
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WORD_BITS-1:0] word_store [DEPTH];
  logic [WORD_BITS-1:0] rd_data;
  logic [AW-1:0]        rd_addr;
  logic [AW-1:0]        wr_addr;
  logic                 wr_en;

  logic [4:0]           cap_reg;
  logic [CW-1:0]        cap_eff;
  logic [AW-1:0]        head;
  logic [AW-1:0]        tail;
  logic [CW-1:0]        count;
  logic [AW-1:0]        scan_slot;
  logic [CW-1:0]        scan_idx;

  rbd_pkg::op_t         op_q;
  logic [WORD_BITS-1:0] x_q;

  rbd_pkg::status_t     res_status;
  logic [31:0]          res_data;
  logic [AW-1:0]        res_slot;

  logic                 full;
  logic                 empty;
  logic                 match;
  logic                 scan_last;

  function automatic logic [AW-1:0] step_up(logic [AW-1:0] s, logic [CW-1:0] cap);
    logic [CW:0] s1;
    s1 = (CW + 1)'(s) + (CW + 1)'(1);
    if (s1 >= (CW + 1)'(cap)) return '0;
    return AW'(s1);
  endfunction

  function automatic logic [AW-1:0] step_down(logic [AW-1:0] s, logic [CW-1:0] cap);
    if (s == '0 || CW'(s) >= cap) return AW'(cap - CW'(1));
    return s - AW'(1);
  endfunction

  // out of range capacity values clamp to 1..DEPTH
  always_comb begin
    if (cap_reg == 5'd0) cap_eff = CW'(1);
    else if (int'(cap_reg) > DEPTH) cap_eff = CW'(DEPTH);
    else cap_eff = CW'(cap_reg);
  end

  assign full      = (count >= cap_eff);
  assign empty     = (count == '0);
  assign match     = (rd_data == x_q);
  assign scan_last = ((scan_idx + CW'(1)) >= count);

  assign dp_status.op        = op_q;
  assign dp_status.empty     = empty;
  assign dp_status.match     = match;
  assign dp_status.scan_last = scan_last;
  assign dp_status.out_free  = !out_valid || !out_stall;

  assign cap_value = cap_reg;

  // store port addresses
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = tail;
    rd_addr = head;
    if (cmd.exec) begin
      case (op_q)
        rbd_pkg::OP_PUSH_FRONT: begin
          wr_en   = !full;
          wr_addr = step_down(head, cap_eff);
        end
        rbd_pkg::OP_PUSH_BACK: begin
          wr_en   = !full;
          wr_addr = tail;
        end
        rbd_pkg::OP_POP_BACK,
        rbd_pkg::OP_PEEK_BACK: rd_addr = step_down(tail, cap_eff);
        default: rd_addr = head;
      endcase
    end else if (cmd.scan_step) begin
      rd_addr = step_up(scan_slot, cap_eff);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) word_store[wr_addr] <= x_q;
    rd_data <= word_store[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cap_reg   <= 5'd16;
      head      <= '0;
      tail      <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        cap_reg <= cfg_wdata;
        head    <= '0;
        tail    <= '0;
        count   <= '0;
      end
      if (cmd.exec) begin
        case (op_q)
          rbd_pkg::OP_PUSH_FRONT: begin
            if (!full) begin
              head  <= step_down(head, cap_eff);
              count <= count + CW'(1);
            end
          end
          rbd_pkg::OP_PUSH_BACK: begin
            if (!full) begin
              tail  <= step_up(tail, cap_eff);
              count <= count + CW'(1);
            end
          end
          rbd_pkg::OP_POP_FRONT: begin
            if (!empty) begin
              head  <= step_up(head, cap_eff);
              count <= count - CW'(1);
            end
          end
          rbd_pkg::OP_POP_BACK: begin
            if (!empty) begin
              tail  <= step_down(tail, cap_eff);
              count <= count - CW'(1);
            end
          end
          rbd_pkg::OP_CLEAR: begin
            head  <= '0;
            tail  <= '0;
            count <= '0;
          end
          default: begin
          end
        endcase
      end
      if (cmd.load_out) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_q <= rbd_pkg::op_t'(operation);
      x_q  <= WORD_BITS'($unsigned(data_in));
    end
    if (cmd.exec) begin
      res_status <= rbd_pkg::ST_OK;
      res_data   <= '0;
      res_slot   <= '0;
      scan_slot  <= head;
      scan_idx   <= '0;
      case (op_q)
        rbd_pkg::OP_PUSH_FRONT,
        rbd_pkg::OP_PUSH_BACK: begin
          if (full) res_status <= rbd_pkg::ST_FULL;
        end
        rbd_pkg::OP_POP_FRONT,
        rbd_pkg::OP_POP_BACK,
        rbd_pkg::OP_PEEK_FRONT,
        rbd_pkg::OP_PEEK_BACK: begin
          if (empty) res_status <= rbd_pkg::ST_EMPTY;
        end
        rbd_pkg::OP_SEARCH: begin
          if (empty) res_status <= rbd_pkg::ST_NOTFOUND;
        end
        default: begin
        end
      endcase
    end
    if (cmd.read_done) res_data <= 32'(rd_data);
    if (cmd.scan_step) begin
      if (match) begin
        res_slot <= scan_slot;
      end else if (scan_last) begin
        res_status <= rbd_pkg::ST_NOTFOUND;
      end else begin
        scan_slot <= step_up(scan_slot, cap_eff);
        scan_idx  <= scan_idx + CW'(1);
      end
    end
    if (cmd.load_out) begin
      status     <= res_status;
      data_out   <= res_data;
      found_slot <= 4'(res_slot);
      count_now  <= 5'(count);
    end
  end

endmodule

[src/ring_buffer_deque_top.sv]
`timescale 1ns / 1ps
// Double-ended queue of words in a circular store, with search and clear.
// Takes one item at a time: push, clear and every refused request pass from
// the execute state to the result register; pop and peek pass through a read
// state as well, and a search through a scan state that compares entries
// up to the first hit or the count held. The next item can be accepted in the
// cycle after the result is loaded, and the load waits while a stalled
// earlier result still holds the output register. The read state comes from
// the single read port of the word store, whose read data is registered; the
// search steps one entry per cycle. A finished result waits in the output
// register while the next item is accepted. Writing capacity_in_use (byte
// address 0) also empties the queue; store entries hold no reset value.
module ring_buffer_deque_top #(
  parameter int DEPTH     = 16,
  parameter int WORD_BITS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         operation,
  input  logic signed [31:0] data_in,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         status,
  output logic signed [31:0] data_out,
  output logic [3:0]         found_slot,
  output logic [4:0]         count_now,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  rbd_pkg::ctl_cmd_t   cmd;
  rbd_pkg::dp_status_t dp_status;
  logic                cfg_we;
  logic [4:0]          cap_value;

  assign pready = 1'b1;
  // only register index 0 exists
  assign cfg_we = psel && penable && pwrite && (paddr[2] == 1'b0);
  assign prdata = (paddr[2] == 1'b0) ? {27'd0, cap_value} : 32'd0;

  rbd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .dp_status (dp_status),
    .in_stall  (in_stall),
    .cmd       (cmd)
  );

  rbd_datapath #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .dp_status  (dp_status),
    .operation  (operation),
    .data_in    (data_in),
    .cfg_we     (cfg_we),
    .cfg_wdata  (pwdata[4:0]),
    .cap_value  (cap_value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .status     (status),
    .data_out   (data_out),
    .found_slot (found_slot),
    .count_now  (count_now)
  );

endmodule
